// ===== design/crout_pkg.sv =====
// ----------------------------------------------------------------------------
// crout_pkg: shared constants and helpers for the Crout LU block
// Data width, default parameter values, reset order and saturation helper.
// ----------------------------------------------------------------------------
package crout_pkg;

    localparam int DATA_W            = 32;
    localparam int ORDER_W           = 4;
    localparam int IDX_W             = 3;
    localparam int MAX_ORDER_DEFAULT = 8;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [63:0]       acc_t;

    // clamp a 64-bit accumulator to the signed 32-bit range
    function automatic word_t sat32(input acc_t x);
        word_t r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/crout_lu_decomposition.sv =====
// ----------------------------------------------------------------------------
// crout_lu_decomposition: Crout LU factorization without pivoting, Q16.16
// Loads n*n elements row-major, factors in place, then sends compact L\U.
// ----------------------------------------------------------------------------
// Load: one element per cycle. Factor: each multiply-accumulate reads L, reads U,
// multiplies and accumulates (one memory read port); each entry reads A and
// finishes, and each divide runs a bit-serial divider. Emit: each result is read, captured and held until m_ready.
// Reset (synchronous, active low) sets order 8, clears load count and flag;
// the matrix memory is not cleared.
module crout_lu_decomposition #(
    parameter int MAX_ORDER = crout_pkg::MAX_ORDER_DEFAULT,
    parameter int FRAC_BITS = crout_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crout_pkg::ORDER_W-1:0]   cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  crout_pkg::word_t                s_element,
    output logic                            m_valid,
    input  logic                            m_ready,
    output crout_pkg::word_t                m_value,
    output logic [crout_pkg::IDX_W-1:0]     m_row,
    output logic [crout_pkg::IDX_W-1:0]     m_col,
    output logic                            m_from_lower,
    output logic                            m_pivot_zero,
    output logic                            m_last
);
    import crout_pkg::*;

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int LW    = $clog2(DEPTH + 1);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_RD_A   = 4'd1;
    localparam logic [3:0] S_GET_A  = 4'd2;
    localparam logic [3:0] S_RD_L   = 4'd3;
    localparam logic [3:0] S_RD_U   = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_E_RD   = 4'd9;
    localparam logic [3:0] S_E_CAP  = 4'd10;
    localparam logic [3:0] S_E_WAIT = 4'd11;

    logic [3:0]         state_reg;
    logic [ORDER_W-1:0] order_reg;
    logic [LW-1:0]      load_cnt_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      k_reg;
    logic               lower_reg;
    logic               zp_reg;
    logic               div_start_reg;
    acc_t               acc_reg;
    acc_t               prod_reg;
    word_t              opl_reg;
    word_t              piv_reg;

    logic [CW-1:0]      n_eff;
    logic [LW-1:0]      total;
    logic               last_elem;
    word_t              sat_val;
    acc_t               rnd_prod;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    word_t              mem_wdata;
    logic [AW-1:0]      mem_raddr;
    word_t              mem_rdata;

    logic               div_done;
    word_t              div_quot;

    // linear address r*n+c
    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c,
                                              input logic [CW-1:0] n);
        logic [2*CW:0] a;
        a = (2*CW+1)'(r) * (2*CW+1)'(n) + (2*CW+1)'(c);
        return a[AW-1:0];
    endfunction

    // effective order, clamped to 1..MAX_ORDER
    always_comb begin
        if (order_reg == '0) begin
            n_eff = CW'(1);
        end else if (32'(order_reg) > MAX_ORDER) begin
            n_eff = CW'(MAX_ORDER);
        end else begin
            n_eff = CW'(order_reg);
        end
    end

    assign total     = LW'(n_eff) * LW'(n_eff);
    assign last_elem = (load_cnt_reg + 1'b1) >= total;
    assign sat_val   = sat32(acc_reg);
    assign rnd_prod  = (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_LOAD);

    // memory write select
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = s_element;
        case (state_reg)
            S_LOAD: begin
                mem_we    = s_valid;
                mem_waddr = AW'(load_cnt_reg);
                mem_wdata = s_element;
            end
            S_FIN: begin
                mem_we    = lower_reg;
                mem_waddr = addr_of(j_reg, i_reg, n_eff);
                mem_wdata = sat_val;
            end
            S_DIV: begin
                mem_we    = div_done;
                mem_waddr = addr_of(i_reg, j_reg, n_eff);
                mem_wdata = div_quot;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // memory read address
    always_comb begin
        case (state_reg)
            S_RD_A:  mem_raddr = lower_reg ? addr_of(j_reg, i_reg, n_eff)
                                           : addr_of(i_reg, j_reg, n_eff);
            S_RD_L:  mem_raddr = lower_reg ? addr_of(j_reg, k_reg, n_eff)
                                           : addr_of(i_reg, k_reg, n_eff);
            S_RD_U:  mem_raddr = addr_of(k_reg, lower_reg ? i_reg : j_reg, n_eff);
            S_E_RD:  mem_raddr = addr_of(i_reg, j_reg, n_eff);
            default: mem_raddr = '0;
        endcase
    end

    // sequencer: load, factor in place, emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            order_reg     <= ORDER_RESET;
            load_cnt_reg  <= '0;
            zp_reg        <= 1'b0;
            m_valid       <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            case (state_reg)
                S_LOAD: begin
                    if (s_valid) begin
                        if (last_elem) begin
                            load_cnt_reg <= '0;
                            i_reg        <= '0;
                            j_reg        <= '0;
                            lower_reg    <= 1'b1;
                            zp_reg       <= 1'b0;
                            state_reg    <= S_RD_A;
                        end else begin
                            load_cnt_reg <= load_cnt_reg + 1'b1;
                        end
                    end
                end
                S_RD_A: begin
                    state_reg <= S_GET_A;
                end
                S_GET_A: begin
                    acc_reg   <= acc_t'(mem_rdata);
                    k_reg     <= '0;
                    state_reg <= (i_reg == '0) ? S_FIN : S_RD_L;
                end
                S_RD_L: begin
                    state_reg <= S_RD_U;
                end
                S_RD_U: begin
                    opl_reg   <= mem_rdata;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= opl_reg * mem_rdata;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg   <= acc_reg - rnd_prod;
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= ((k_reg + 1'b1) < i_reg) ? S_RD_L : S_FIN;
                end
                S_FIN: begin
                    if (lower_reg) begin
                        if (j_reg == i_reg) begin
                            piv_reg <= sat_val;
                            if (sat_val == '0) begin
                                zp_reg <= 1'b1;
                            end
                        end
                        if ((j_reg + 1'b1) < n_eff) begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_RD_A;
                        end else if ((i_reg + 1'b1) < n_eff) begin
                            lower_reg <= 1'b0;
                            j_reg     <= i_reg + 1'b1;
                            state_reg <= S_RD_A;
                        end else begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= S_E_RD;
                        end
                    end else begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if ((j_reg + 1'b1) < n_eff) begin
                            j_reg <= j_reg + 1'b1;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            j_reg     <= i_reg + 1'b1;
                            lower_reg <= 1'b1;
                        end
                        state_reg <= S_RD_A;
                    end
                end
                S_E_RD: begin
                    state_reg <= S_E_CAP;
                end
                S_E_CAP: begin
                    m_value      <= mem_rdata;
                    m_row        <= IDX_W'(i_reg);
                    m_col        <= IDX_W'(j_reg);
                    m_from_lower <= (i_reg >= j_reg);
                    m_pivot_zero <= zp_reg;
                    m_last       <= ((i_reg + 1'b1) == n_eff) && ((j_reg + 1'b1) == n_eff);
                    m_valid      <= 1'b1;
                    state_reg    <= S_E_WAIT;
                end
                S_E_WAIT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        if (m_last) begin
                            state_reg <= S_LOAD;
                        end else begin
                            if ((j_reg + 1'b1) < n_eff) begin
                                j_reg <= j_reg + 1'b1;
                            end else begin
                                i_reg <= i_reg + 1'b1;
                                j_reg <= '0;
                            end
                            state_reg <= S_E_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
            // order write clears the load count and zero-pivot flag; the state is unchanged
            if (cfg_valid) begin
                order_reg    <= cfg_data;
                load_cnt_reg <= '0;
                zp_reg       <= 1'b0;
            end
        end
    end

    crout_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    crout_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (sat_val),
        .den     (piv_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

endmodule

// ===== design/crout_store.sv =====
// ----------------------------------------------------------------------------
// crout_store: matrix memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module crout_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  crout_pkg::word_t          wdata,
    input  logic [AW-1:0]             raddr,
    output crout_pkg::word_t          rdata
);
    import crout_pkg::*;

    word_t mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/crout_div.sv =====
// ----------------------------------------------------------------------------
// crout_div: fixed-point divider
// (num * 2^FRAC_BITS) / den, truncated toward zero, saturated to 32 bits.
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crout_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  crout_pkg::word_t num,
    input  crout_pkg::word_t den,
    output logic             done,
    output crout_pkg::word_t quot
);
    import crout_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [DATA_W:0]   rem_reg;
    logic [NW-1:0]     quo_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic              neg_reg;
    logic              done_reg;
    word_t             quot_reg;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W-1:0] dmag_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    assign num_mag = num[DATA_W-1] ? (~num + 1'b1) : num;
    assign den_mag = den[DATA_W-1] ? (~den + 1'b1) : den;

    // one restoring step
    assign shifted = {rem_reg[DATA_W-1:0], quo_reg[NW-1]};
    assign trial   = shifted - {1'b0, dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
                if (den == '0) begin
                    // zero pivot: saturate by numerator sign
                    if (num == '0) begin
                        quot_reg <= '0;
                    end else if (num[DATA_W-1]) begin
                        quot_reg <= 32'sh8000_0000;
                    end else begin
                        quot_reg <= 32'sh7FFF_FFFF;
                    end
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= '0;
                    quo_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
                    dmag_reg <= den_mag;
                    cnt_reg  <= CW'(NW);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (!trial[DATA_W]) begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                // apply sign and saturate
                if (neg_reg) begin
                    if (quo_reg > NW'(64'h8000_0000)) begin
                        quot_reg <= 32'sh8000_0000;
                    end else begin
                        quot_reg <= ~quo_reg[DATA_W-1:0] + 1'b1;
                    end
                end else begin
                    if (quo_reg > NW'(64'h7FFF_FFFF)) begin
                        quot_reg <= 32'sh7FFF_FFFF;
                    end else begin
                        quot_reg <= quo_reg[DATA_W-1:0];
                    end
                end
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
